// ----- rtl/half_duplex_uart_with_rx_fifo_unit_defines.svh -----
// Assertion macros shared by the UART block.
`ifndef HALF_DUPLEX_UART_WITH_RX_FIFO_UNIT_DEFINES_SVH
`define HALF_DUPLEX_UART_WITH_RX_FIFO_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HDUART_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HDUART_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hduart_pkg.sv -----
// Types and constants shared by the UART block and its receive ring.
`timescale 1ns / 1ps

package hduart_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 16;
	localparam int unsigned CFG_IDX_W      = 2;

	localparam logic [7:0] START_DELAY_RST = 8'd39;
	localparam logic [7:0] BIT_PERIOD_RST  = 8'd26;
	localparam logic [3:0] STOP_COUNT_RST  = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SEND = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RX   = 2'd1,
		MODE_TX   = 2'd2
	} line_mode_t;

endpackage

// ----- rtl/half_duplex_uart_with_rx_fifo_unit.sv -----
// Half-duplex 8N1 UART with a receive ring, advanced one request at a time. The block takes
// one request per clock while in_stall is low, and each request gives exactly one result. The
// line state, the ring pointers and the ring read all update at the accepting edge. The request's
// status is registered in the first stage, and the result is loaded into the output register
// from there when the output register is empty or being taken, once the ring RAM's registered
// read data is there. Back-to-back requests run at full rate while the output is not stalled.
// Ring entries are not cleared after reset and no clearing pass runs, so the block takes
// requests from the first cycle after reset. Configuration writes are always taken and must
// only be made while the block is idle.
`timescale 1ns / 1ps
`include "half_duplex_uart_with_rx_fifo_unit_defines.svh"

module half_duplex_uart_with_rx_fifo_unit #(
	parameter int unsigned FIFO_DEPTH = hduart_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hduart_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic                             rx_line,
	input  logic [7:0]                       send_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             tx_line,
	output logic [7:0]                       read_byte,
	output logic                             read_valid,
	output logic                             send_accepted,
	output logic                             sending,
	output logic                             receiving,
	output logic [4:0]                       fifo_level,
	output logic                             overrun
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	// Configuration registers
	logic [7:0] start_delay_q;
	logic [7:0] bit_period_q;
	logic [3:0] stop_count_q;

	// Line and ring state
	hduart_pkg::line_mode_t mode_q, mode_d;
	logic [7:0]       shift_q, shift_d;
	logic [3:0]       bit_idx_q, bit_idx_d;
	logic [7:0]       tick_cnt_q, tick_cnt_d;
	logic [7:0]       tick_tgt_q, tick_tgt_d;
	logic             tx_q, tx_d;
	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             ovr_q, ovr_d;

	logic accept;
	logic push;
	logic pop;
	logic sent;

	// First pipeline stage: status of the request, waiting for the ring read data
	logic       valid_s1;
	logic       tx_s1;
	logic       rd_ok_s1;
	logic       acc_s1;
	logic       sending_s1;
	logic       receiving_s1;
	logic [4:0] level_s1;
	logic       ovr_s1;
	logic       s1_adv;

	// Output register
	logic       out_valid_q;
	logic       tx_line_q;
	logic [7:0] read_byte_q;
	logic       read_valid_q;
	logic       send_accepted_q;
	logic       sending_q;
	logic       receiving_q;
	logic [4:0] fifo_level_q;
	logic       overrun_q;

	logic [7:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= hduart_pkg::START_DELAY_RST;
			bit_period_q  <= hduart_pkg::BIT_PERIOD_RST;
			stop_count_q  <= hduart_pkg::STOP_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				hduart_pkg::REG_START_DELAY: start_delay_q <= cfg_data;
				hduart_pkg::REG_BIT_PERIOD:  bit_period_q  <= cfg_data;
				hduart_pkg::REG_STOP_COUNT:  stop_count_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// The first stage moves on when the output register is empty or being taken.
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		logic [8:0] tick_sum;
		logic       fire;
		logic [3:0] idx_nx;
		logic       push_req;

		mode_d     = mode_q;
		shift_d    = shift_q;
		bit_idx_d  = bit_idx_q;
		tick_cnt_d = tick_cnt_q;
		tick_tgt_d = tick_tgt_q;
		tx_d       = tx_q;
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		count_d    = count_q;
		ovr_d      = ovr_q;
		push       = 1'b0;
		pop        = 1'b0;
		sent       = 1'b0;
		push_req   = 1'b0;

		tick_sum = {1'b0, tick_cnt_q} + 9'd1;
		fire     = tick_sum >= {1'b0, tick_tgt_q};
		idx_nx   = bit_idx_q + 4'd1;

		if (accept) begin
			case (cmd)
				hduart_pkg::CMD_TICK: begin
					if (mode_q != hduart_pkg::MODE_RX && mode_q != hduart_pkg::MODE_TX) begin
						// Idle: a low receive line is taken as a start bit.
						mode_d = hduart_pkg::MODE_IDLE;
						if (!rx_line) begin
							mode_d     = hduart_pkg::MODE_RX;
							shift_d    = 8'h00;
							bit_idx_d  = 4'hF;
							tick_cnt_d = 8'h00;
							tick_tgt_d = start_delay_q;
						end
					end else if (fire) begin
						tick_cnt_d = 8'h00;
						tick_tgt_d = bit_period_q;
						bit_idx_d  = idx_nx;
						if (mode_q == hduart_pkg::MODE_TX) begin
							if (idx_nx < 4'd8) begin
								tx_d    = shift_q[0];
								shift_d = shift_q >> 1;
							end else begin
								// Stop time; a stop count below eight behaves as eight.
								tx_d = 1'b1;
								if (idx_nx >= stop_count_q) begin
									mode_d = hduart_pkg::MODE_IDLE;
								end
							end
						end else begin
							if (idx_nx < 4'd8) begin
								shift_d = shift_q | (8'(rx_line) << idx_nx[2:0]);
							end else begin
								mode_d   = hduart_pkg::MODE_IDLE;
								push_req = rx_line;
							end
						end
					end else begin
						tick_cnt_d = tick_sum[7:0];
					end
				end
				hduart_pkg::CMD_SEND: begin
					if (mode_q != hduart_pkg::MODE_TX) begin
						tx_d       = 1'b0;
						tick_cnt_d = 8'h00;
						tick_tgt_d = bit_period_q;
						mode_d     = hduart_pkg::MODE_TX;
						shift_d    = send_byte;
						bit_idx_d  = 4'hF;
						sent       = 1'b1;
					end
				end
				hduart_pkg::CMD_READ: begin
					if (count_q != '0) begin
						pop      = 1'b1;
						rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
						count_d  = count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end

		// A good byte with the ring full is dropped and leaves the pointers alone.
		if (push_req) begin
			if (count_q == CNT_FULL) begin
				ovr_d = 1'b1;
			end else begin
				push     = 1'b1;
				wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				count_d  = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= hduart_pkg::MODE_IDLE;
			shift_q    <= 8'h00;
			bit_idx_q  <= 4'hF;
			tick_cnt_q <= 8'h00;
			tick_tgt_q <= 8'h00;
			tx_q       <= 1'b1;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			ovr_q      <= 1'b0;
		end else begin
			mode_q     <= mode_d;
			shift_q    <= shift_d;
			bit_idx_q  <= bit_idx_d;
			tick_cnt_q <= tick_cnt_d;
			tick_tgt_q <= tick_tgt_d;
			tx_q       <= tx_d;
			wr_ptr_q   <= wr_ptr_d;
			rd_ptr_q   <= rd_ptr_d;
			count_q    <= count_d;
			ovr_q      <= ovr_d;
		end
	end

	hduart_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (wr_ptr_q),
		.wdata (shift_q),
		.re    (pop),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_s1        <= tx_d;
			rd_ok_s1     <= pop;
			acc_s1       <= sent;
			sending_s1   <= mode_d == hduart_pkg::MODE_TX;
			receiving_s1 <= mode_d == hduart_pkg::MODE_RX;
			level_s1     <= 5'(count_d);
			ovr_s1       <= ovr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The ring read data holds while the first stage waits, as no new read is issued then.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tx_line_q       <= tx_s1;
			read_byte_q     <= rd_ok_s1 ? ram_rdata : 8'h00;
			read_valid_q    <= rd_ok_s1;
			send_accepted_q <= acc_s1;
			sending_q       <= sending_s1;
			receiving_q     <= receiving_s1;
			fifo_level_q    <= level_s1;
			overrun_q       <= ovr_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_line       = tx_line_q;
	assign read_byte     = read_byte_q;
	assign read_valid    = read_valid_q;
	assign send_accepted = send_accepted_q;
	assign sending       = sending_q;
	assign receiving     = receiving_q;
	assign fifo_level    = fifo_level_q;
	assign overrun       = overrun_q;

	`HDUART_ASSERT_NEXT(a_push_count, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1), "ring count did not rise on a push")
	`HDUART_ASSERT_NEXT(a_pop_count, pop && !push, count_q == CNT_W'($past(count_q) - 1'b1), "ring count did not fall on a pop")
	`HDUART_ASSERT_NEXT(a_ovr_sticky, ovr_q, ovr_q, "overrun flag cleared")
	`HDUART_ASSERT_SAME(a_empty_read, out_valid_q && !read_valid_q, read_byte_q == 8'h00, "read byte not zero on a failed read")

endmodule

// ----- rtl/hduart_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hduart_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = hduart_pkg::FIFO_DEPTH_DEF,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds its value until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/half_duplex_uart_with_rx_fifo_unit_test.sv -----
// Self-checking testbench for the half-duplex UART with its receive ring.
`timescale 1ns / 1ps

module half_duplex_uart_with_rx_fifo_unit_test;

	localparam logic [1:0] CMD_NOP        = 2'd3;
	localparam int         RING_DEPTH     = hduart_pkg::FIFO_DEPTH_DEF;
	localparam int         PLAN_ROWS      = 25;
	localparam int         FAST_ROWS      = 3;
	localparam int         PHASES         = 9;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         REPORT_LIMIT   = 10;

	typedef struct packed {
		logic       tx_line;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       send_accepted;
		logic       sending;
		logic       receiving;
		logic [4:0] fifo_level;
		logic       overrun;
	} uart_status_t;

	typedef struct {
		logic [1:0]   op;
		logic         rx;
		logic [7:0]   data;
		bit           typed;
		uart_status_t want;
	} plan_row_t;

	localparam uart_status_t IDLE_STATUS  = '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0};
	localparam uart_status_t SEND_TAKEN   = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 1'b0};
	localparam uart_status_t SEND_REFUSED = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0, 1'b0};

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [hduart_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                       cfg_data;
	logic                             in_valid;
	logic                             in_stall;
	logic [1:0]                       cmd;
	logic                             rx_line;
	logic [7:0]                       send_byte;
	logic                             out_valid;
	logic                             out_stall;
	logic                             tx_line;
	logic [7:0]                       read_byte;
	logic                             read_valid;
	logic                             send_accepted;
	logic                             sending;
	logic                             receiving;
	logic [4:0]                       fifo_level;
	logic                             overrun;

	// Typed expectation travelling with the request it belongs to.
	bit           row_typed;
	uart_status_t row_status;

	// Shadow copy of the block's registers and line state.
	logic [7:0]             start_delay_q;
	logic [7:0]             bit_period_q;
	logic [3:0]             stop_count_q;
	hduart_pkg::line_mode_t mode_q;
	logic [7:0]             shreg_q;
	logic [3:0]             bidx_q;
	logic [7:0]             tcount_q;
	logic [7:0]             ttarget_q;
	logic                   tx_q;
	logic [7:0]             ring_q [RING_DEPTH];
	int unsigned            wptr_q;
	int unsigned            rptr_q;
	int unsigned            count_q;
	logic                   overrun_q;

	uart_status_t status_due [$];
	uart_status_t predicted;
	uart_status_t seen;
	uart_status_t want;
	int unsigned  mismatches;
	int unsigned  results_checked;
	int unsigned  idle_cycles;

	int unsigned issued;
	int unsigned phase_end;
	int          read_bias;
	bit          reads_on;
	bit          sender_calm;
	bit          hold_request;
	int          stall_run;
	int          calm_left;
	plan_row_t   plan [PLAN_ROWS];

	half_duplex_uart_with_rx_fifo_unit u_dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_stall,
		.cmd,
		.rx_line,
		.send_byte,
		.out_valid,
		.out_stall,
		.tx_line,
		.read_byte,
		.read_valid,
		.send_accepted,
		.sending,
		.receiving,
		.fifo_level,
		.overrun
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advances the shadow UART by one request and returns the status it reports.
	function automatic uart_status_t advance_uart(logic [1:0] op, logic rx, logic [7:0] data);
		uart_status_t r;
		logic [8:0]   next_count;
		logic         fire;
		r    = '0;
		fire = 1'b0;
		case (op)
			hduart_pkg::CMD_TICK: begin
				if (mode_q == hduart_pkg::MODE_IDLE) begin
					if (!rx) begin
						mode_q    = hduart_pkg::MODE_RX;
						shreg_q   = 8'h00;
						bidx_q    = 4'hF;
						tcount_q  = 8'h00;
						ttarget_q = start_delay_q;
					end
				end else begin
					next_count = {1'b0, tcount_q} + 9'd1;
					if (next_count >= {1'b0, ttarget_q}) begin
						tcount_q  = 8'h00;
						ttarget_q = bit_period_q;
						fire      = 1'b1;
					end else begin
						tcount_q = next_count[7:0];
					end
				end
			end
			hduart_pkg::CMD_SEND: begin
				if (mode_q != hduart_pkg::MODE_TX) begin
					tx_q            = 1'b0;
					tcount_q        = 8'h00;
					ttarget_q       = bit_period_q;
					mode_q          = hduart_pkg::MODE_TX;
					shreg_q         = data;
					bidx_q          = 4'hF;
					r.send_accepted = 1'b1;
				end
			end
			hduart_pkg::CMD_READ: begin
				if (count_q != 0) begin
					r.read_byte  = ring_q[rptr_q];
					r.read_valid = 1'b1;
					rptr_q       = (rptr_q + 1) % RING_DEPTH;
					count_q      = count_q - 1;
				end
			end
			default: ;
		endcase
		if (fire) begin
			bidx_q = bidx_q + 4'd1;
			if (mode_q == hduart_pkg::MODE_TX) begin
				if (bidx_q < 4'd8) begin
					tx_q    = shreg_q[0];
					shreg_q = shreg_q >> 1;
				end else begin
					tx_q = 1'b1;
					if (bidx_q >= stop_count_q)
						mode_q = hduart_pkg::MODE_IDLE;
				end
			end else if (bidx_q < 4'd8) begin
				shreg_q[bidx_q[2:0]] = shreg_q[bidx_q[2:0]] | rx;
			end else begin
				// A low stop bit drops the byte; a full ring drops it and raises overrun.
				mode_q = hduart_pkg::MODE_IDLE;
				if (rx) begin
					if (count_q >= RING_DEPTH) begin
						overrun_q = 1'b1;
					end else begin
						ring_q[wptr_q] = shreg_q;
						wptr_q         = (wptr_q + 1) % RING_DEPTH;
						count_q        = count_q + 1;
					end
				end
			end
		end
		r.tx_line    = tx_q;
		r.sending    = (mode_q == hduart_pkg::MODE_TX);
		r.receiving  = (mode_q == hduart_pkg::MODE_RX);
		r.fifo_level = count_q[4:0];
		r.overrun    = overrun_q;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted = advance_uart(cmd, rx_line, send_byte);
				status_due.push_back(row_typed ? row_status : predicted);
			end
			if (out_valid && !out_stall) begin
				seen = '{tx_line, read_byte, read_valid, send_accepted, sending, receiving,
					fifo_level, overrun};
				results_checked++;
				if (status_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d arrived with nothing expected", results_checked);
				end else begin
					want = status_due.pop_front();
					if (seen.tx_line !== want.tx_line || seen.read_byte !== want.read_byte ||
						seen.read_valid !== want.read_valid ||
						seen.send_accepted !== want.send_accepted ||
						seen.sending !== want.sending || seen.receiving !== want.receiving ||
						seen.fifo_level !== want.fifo_level || seen.overrun !== want.overrun) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result %0d expected tx=%b byte=%h rv=%b acc=%b snd=%b rcv=%b lvl=%0d ovr=%b",
								results_checked, want.tx_line, want.read_byte, want.read_valid,
								want.send_accepted, want.sending, want.receiving,
								want.fifo_level, want.overrun);
							$display("result %0d actual   tx=%b byte=%h rv=%b acc=%b snd=%b rcv=%b lvl=%0d ovr=%b",
								results_checked, seen.tx_line, seen.read_byte, seen.read_valid,
								seen.send_accepted, seen.sending, seen.receiving,
								seen.fifo_level, seen.overrun);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hduart_pkg::REG_START_DELAY: start_delay_q = cfg_data;
					hduart_pkg::REG_BIT_PERIOD:  bit_period_q  = cfg_data;
					hduart_pkg::REG_STOP_COUNT:  stop_count_q  = cfg_data[3:0];
					default: ;
				endcase
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[half_duplex_uart_with_rx_fifo_unit] ERROR");
					$finish;
				end
			end
		end
	end

	function automatic int gap_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: short random stalls, quiet stretches, and one long hold when asked.
	initial begin
		out_stall = 1'b0;
		stall_run = 0;
		calm_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_run != 0) begin
				out_stall <= 1'b1;
				stall_run--;
			end else begin
				out_stall <= 1'b0;
				if (calm_left != 0)
					calm_left--;
				else if ($urandom_range(0, 199) == 0)
					calm_left = 300;
				else if ($urandom_range(0, 4) == 0)
					stall_run = gap_length();
			end
		end
	end

	// Entered and left at a falling edge; valid stays high if no gap follows.
	task automatic push_request(input logic [1:0] op, input logic rx, input logic [7:0] data,
		input bit typed, input uart_status_t status);
		int gap;
		cmd        <= op;
		rx_line    <= rx;
		send_byte  <= data;
		row_typed  <= typed;
		row_status <= status;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		issued++;
		@(negedge clk);
		if (!sender_calm && $urandom_range(0, 2) == 0) begin
			gap = gap_length();
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_register(input logic [hduart_pkg::CFG_IDX_W-1:0] index,
		input logic [7:0] data);
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Lets any frame on the line run out before the registers change.
	task automatic apply_config(input logic [7:0] delay, input logic [7:0] period,
		input logic [7:0] stop);
		while (mode_q != hduart_pkg::MODE_IDLE)
			push_request(hduart_pkg::CMD_TICK, 1'b1, 8'($urandom), 1'b0, '0);
		write_register(hduart_pkg::REG_START_DELAY, delay);
		write_register(hduart_pkg::REG_BIT_PERIOD, period);
		write_register(hduart_pkg::REG_STOP_COUNT, stop);
	endtask

	task automatic offer(input logic [1:0] op, input logic rx, input logic [7:0] data);
		if (issued < phase_end)
			push_request(op, rx, data, 1'b0, '0);
	endtask

	task automatic offer_tick(input logic level);
		if (reads_on && $urandom_range(0, 99) < read_bias)
			offer(hduart_pkg::CMD_READ, 1'($urandom), 8'($urandom));
		if ($urandom_range(0, 399) == 0)
			offer(hduart_pkg::CMD_SEND, 1'($urandom), 8'($urandom));
		offer(hduart_pkg::CMD_TICK, level, 8'($urandom));
	endtask

	// A whole 8N1 frame on the receive line, each bit held for its sampling window.
	task automatic receive_frame();
		logic [7:0] bits;
		logic       stop_ok;
		logic       level;
		int         span;
		bits    = 8'($urandom);
		stop_ok = ($urandom_range(0, 7) != 0);
		offer_tick(1'b0);
		for (int k = 0; k < 9; k++) begin
			span  = (k == 0) ? int'(start_delay_q) : int'(bit_period_q);
			level = (k < 8) ? bits[k] : stop_ok;
			if (span == 0)
				span = 1;
			repeat (span) offer_tick(level);
		end
	endtask

	task automatic send_frame();
		int span;
		int stop_bits;
		span      = (bit_period_q == 8'd0) ? 1 : int'(bit_period_q);
		stop_bits = (stop_count_q < 4'd8) ? 8 : int'(stop_count_q);
		offer(hduart_pkg::CMD_SEND, 1'($urandom), 8'($urandom));
		if ($urandom_range(0, 2) == 0)
			offer(hduart_pkg::CMD_SEND, 1'($urandom), 8'($urandom));
		repeat ((stop_bits + 1) * span + 1) offer_tick($urandom_range(0, 9) != 0);
	endtask

	initial begin
		int          pick;
		int unsigned budget;
		logic [1:0]  noise_op;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = hduart_pkg::CMD_TICK;
		rx_line       = 1'b1;
		send_byte     = 8'h00;
		cfg_valid     = 1'b0;
		cfg_index     = hduart_pkg::REG_START_DELAY;
		cfg_data      = 8'h00;
		row_typed     = 1'b0;
		row_status    = '0;
		sender_calm   = 1'b0;
		hold_request  = 1'b0;
		reads_on      = 1'b1;
		read_bias     = 5;
		issued        = 0;
		phase_end     = 0;
		mismatches    = 0;
		results_checked = 0;
		idle_cycles   = 0;
		start_delay_q = hduart_pkg::START_DELAY_RST;
		bit_period_q  = hduart_pkg::BIT_PERIOD_RST;
		stop_count_q  = hduart_pkg::STOP_COUNT_RST;
		mode_q        = hduart_pkg::MODE_IDLE;
		shreg_q       = 8'h00;
		bidx_q        = 4'hF;
		tcount_q      = 8'h00;
		ttarget_q     = 8'h00;
		tx_q          = 1'b1;
		wptr_q        = 0;
		rptr_q        = 0;
		count_q       = 0;
		overrun_q     = 1'b0;

		// The first rows run on the reset settings; the rest with every timer at zero,
		// so each tick is a bit event and a frame takes ten ticks.
		plan = '{
			'{hduart_pkg::CMD_READ, 1'b1, 8'h00, 1'b1, IDLE_STATUS},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b1, IDLE_STATUS},
			'{CMD_NOP,              1'b0, 8'hFF, 1'b1, IDLE_STATUS},
			'{hduart_pkg::CMD_SEND, 1'b1, 8'hA5, 1'b1, SEND_TAKEN},
			'{hduart_pkg::CMD_SEND, 1'b1, 8'hFF, 1'b1, SEND_REFUSED},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_TICK, 1'b1, 8'h00, 1'b0, '0},
			'{hduart_pkg::CMD_READ, 1'b0, 8'h00, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (i == FAST_ROWS)
				apply_config(8'd0, 8'd0, 8'd0);
			push_request(plan[i].op, plan[i].rx, plan[i].data, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			reads_on  = 1'b1;
			read_bias = $urandom_range(1, 8);
			case (p)
				0: begin apply_config(8'd39, 8'd26, 8'd9); budget = 120; end
				1: begin
					// Only the random noise requests read here, so the ring fills and overruns.
					apply_config(8'd1, 8'd1, 8'd8);
					budget   = 250;
					reads_on = 1'b0;
				end
				2: begin apply_config(8'd3, 8'd2, 8'd10); budget = 180; end
				3: begin apply_config(8'd2, 8'd1, 8'hF5); budget = 150; end
				4: begin apply_config(8'd255, 8'd1, 8'h08); budget = 60; end
				5: begin apply_config(8'd0, 8'd1, 8'h0F); budget = 120; end
				6: begin apply_config(8'd1, 8'd0, 8'd9); budget = 120; end
				default: begin
					apply_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
						8'($urandom_range(8, 10)));
					budget = 80;
				end
			endcase
			if (p == 2)
				hold_request = 1'b1;
			phase_end = issued + budget;
			while (issued < phase_end) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				pick        = $urandom_range(0, 99);
				if (pick < 45) begin
					receive_frame();
				end else if (pick < 65) begin
					send_frame();
				end else if (pick < 80) begin
					if (reads_on)
						repeat ($urandom_range(1, 6))
							offer(hduart_pkg::CMD_READ, 1'($urandom), 8'($urandom));
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 8)) begin
						case ($urandom_range(0, 9))
							6:       noise_op = hduart_pkg::CMD_SEND;
							7:       noise_op = hduart_pkg::CMD_READ;
							8, 9:    noise_op = CMD_NOP;
							default: noise_op = hduart_pkg::CMD_TICK;
						endcase
						offer(noise_op, 1'($urandom), 8'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 10))
						offer(hduart_pkg::CMD_TICK, 1'b1, 8'($urandom));
				end
			end
		end

		in_valid <= 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("[half_duplex_uart_with_rx_fifo_unit] OK");
		else
			$display("[half_duplex_uart_with_rx_fifo_unit] ERROR");
		$finish;
	end

endmodule
